[sv/sca_pkg.sv]
// ============================================================================
// sca_pkg
// Shared types, widths and command codes for the spring chain acceleration
// block.
// ============================================================================
package sca_pkg;

    // Chain length and counter width.
    localparam int MAX_PARTICLES = 1024;
    localparam int CNT_W         = $clog2(MAX_PARTICLES);
    localparam int IDX_W         = 10;

    // Field widths.
    localparam int POS_W  = 32;
    localparam int MASS_W = 24;
    localparam int SPR_W  = 31;

    // Datapath widths.
    localparam int DIF_W  = 33;
    localparam int SUM_W  = 66;
    localparam int ROOT_W = 33;
    localparam int SREM_W = 36;
    localparam int DREM_W = 33;
    localparam int QUO_W  = 32;
    localparam int PROD_W = 66;
    localparam int FRC_W  = 51;
    localparam int RACC_W = 60;

    // Iteration counts of the shared root and divide units.
    localparam int SQRT_STEPS = SUM_W / 2;
    localparam int DIV_STEPS  = QUO_W;
    localparam int ITER_W     = 6;

    // One particle request.
    typedef struct packed {
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic signed [POS_W-1:0]  pos_z;
        logic signed [POS_W-1:0]  vel_x;
        logic signed [POS_W-1:0]  vel_y;
        logic signed [POS_W-1:0]  vel_z;
        logic [MASS_W-1:0]        inv_mass;
        logic [SPR_W-1:0]         spring_rest_length;
        logic [SPR_W-1:0]         spring_stiffness;
        logic [SPR_W-1:0]         spring_damping;
        logic                     spring_active;
        logic                     last_particle;
    } sca_in_t;

    // One acceleration result.
    typedef struct packed {
        logic signed [POS_W-1:0] accel_x;
        logic signed [POS_W-1:0] accel_y;
        logic signed [POS_W-1:0] accel_z;
        logic [IDX_W-1:0]        particle_index;
        logic                    zero_length_flag;
        logic                    end_of_chain;
    } sca_out_t;

    // Datapath operations.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR_F,
        OP_DIFF,
        OP_SQ_MUL,
        OP_SQ_ACC,
        OP_SET_FLAG,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_U_MUL,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_EMAG,
        OP_K_MUL,
        OP_K_ACC,
        OP_C_MUL,
        OP_C_ACC,
        OP_SC_HI,
        OP_SC_LO,
        OP_SC_FIN,
        OP_EMIT,
        OP_SHIFT
    } dp_op_t;

    // Which spring is worked on: subject particle and neighbour.
    typedef enum logic [1:0] {
        PAIR_OLDER,   // middle pulled by older, older spring
        PAIR_NEXT,    // middle pulled by incoming, middle spring
        PAIR_BACK     // incoming pulled by middle, middle spring
    } pair_t;

    // Which result is being produced.
    typedef enum logic [1:0] {
        PH_MID,
        PH_LAST,
        PH_SOLO
    } phase_t;

    // Controller states.
    typedef enum logic [4:0] {
        S_IDLE,
        S_DECIDE,
        S_SHIFT,
        S_DIFF,
        S_SQ_MUL,
        S_SQ_ACC,
        S_ZCHK,
        S_FLAG,
        S_SQRT,
        S_U_MUL,
        S_DIV_INIT,
        S_DIV,
        S_EMAG,
        S_K_MUL,
        S_K_ACC,
        S_C_MUL,
        S_C_ACC,
        S_SPRING_DONE,
        S_SC_HI,
        S_SC_LO,
        S_SC_FIN,
        S_EMIT,
        S_CLEAR2
    } ctrl_state_t;

    // Command from controller to datapath.
    typedef struct packed {
        dp_op_t      op;
        logic [1:0]  comp;
        pair_t       pair;
        logic        mass_new;
        logic        end_mark;
        logic        take;
    } sca_cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic        in_valid;
        logic [1:0]  fill;
        logic        last;
        logic        mid_on;
        logic        older_on;
        logic        sum_zero;
        logic        out_busy;
    } sca_stat_t;

endpackage

[sv/sca_if.sv]
// ============================================================================
// sca_if
// Valid/ready channels for particle requests and acceleration results.
// ============================================================================
interface sca_particle_if;
    logic             valid;
    logic             ready;
    sca_pkg::sca_in_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sca_accel_if;
    logic              valid;
    logic              ready;
    sca_pkg::sca_out_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[sv/sca_ctrl.sv]
// ============================================================================
// sca_ctrl
// Sequencer that walks the datapath through the springs of one particle
// window and hands results to the output register.
// ============================================================================
module sca_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  sca_pkg::sca_stat_t  stat,
    output sca_pkg::sca_cmd_t   cmd
);

    sca_pkg::ctrl_state_t         state_reg, state_next;
    sca_pkg::phase_t              phase_reg, phase_next;
    sca_pkg::pair_t               pair_reg, pair_next;
    logic [1:0]                   comp_reg, comp_next;
    logic [sca_pkg::ITER_W-1:0]   iter_reg, iter_next;

    // Sequencer registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sca_pkg::S_IDLE;
            phase_reg <= sca_pkg::PH_MID;
            pair_reg  <= sca_pkg::PAIR_OLDER;
            comp_reg  <= '0;
            iter_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            pair_reg  <= pair_next;
            comp_reg  <= comp_next;
            iter_reg  <= iter_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        pair_next  = pair_reg;
        comp_next  = comp_reg;
        iter_next  = iter_reg;
        case (state_reg)
            sca_pkg::S_IDLE:
            begin
                if (stat.in_valid)
                begin
                    state_next = sca_pkg::S_DECIDE;
                end
            end
            sca_pkg::S_DECIDE:
            begin
                if (stat.fill == 2'd0)
                begin
                    if (stat.last)
                    begin
                        phase_next = sca_pkg::PH_SOLO;
                        comp_next  = '0;
                        state_next = sca_pkg::S_SC_HI;
                    end
                    else
                    begin
                        state_next = sca_pkg::S_SHIFT;
                    end
                end
                else
                begin
                    phase_next = sca_pkg::PH_MID;
                    if (stat.fill == 2'd2 && stat.older_on)
                    begin
                        pair_next  = sca_pkg::PAIR_OLDER;
                        state_next = sca_pkg::S_DIFF;
                    end
                    else if (stat.mid_on)
                    begin
                        pair_next  = sca_pkg::PAIR_NEXT;
                        state_next = sca_pkg::S_DIFF;
                    end
                    else
                    begin
                        comp_next  = '0;
                        state_next = sca_pkg::S_SC_HI;
                    end
                end
            end
            sca_pkg::S_SHIFT:
            begin
                state_next = sca_pkg::S_IDLE;
            end
            sca_pkg::S_DIFF:
            begin
                comp_next  = '0;
                state_next = sca_pkg::S_SQ_MUL;
            end
            sca_pkg::S_SQ_MUL:
            begin
                state_next = sca_pkg::S_SQ_ACC;
            end
            sca_pkg::S_SQ_ACC:
            begin
                if (comp_reg == 2'd2)
                begin
                    state_next = sca_pkg::S_ZCHK;
                end
                else
                begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = sca_pkg::S_SQ_MUL;
                end
            end
            sca_pkg::S_ZCHK:
            begin
                if (stat.sum_zero)
                begin
                    state_next = sca_pkg::S_FLAG;
                end
                else
                begin
                    iter_next  = '0;
                    state_next = sca_pkg::S_SQRT;
                end
            end
            sca_pkg::S_FLAG:
            begin
                state_next = sca_pkg::S_SPRING_DONE;
            end
            sca_pkg::S_SQRT:
            begin
                if (iter_reg == sca_pkg::ITER_W'(sca_pkg::SQRT_STEPS - 1))
                begin
                    comp_next  = '0;
                    state_next = sca_pkg::S_U_MUL;
                end
                else
                begin
                    iter_next = iter_reg + 1'b1;
                end
            end
            sca_pkg::S_U_MUL:
            begin
                state_next = sca_pkg::S_DIV_INIT;
            end
            sca_pkg::S_DIV_INIT:
            begin
                iter_next  = '0;
                state_next = sca_pkg::S_DIV;
            end
            sca_pkg::S_DIV:
            begin
                if (iter_reg == sca_pkg::ITER_W'(sca_pkg::DIV_STEPS - 1))
                begin
                    state_next = sca_pkg::S_EMAG;
                end
                else
                begin
                    iter_next = iter_reg + 1'b1;
                end
            end
            sca_pkg::S_EMAG:
            begin
                state_next = sca_pkg::S_K_MUL;
            end
            sca_pkg::S_K_MUL:
            begin
                state_next = sca_pkg::S_K_ACC;
            end
            sca_pkg::S_K_ACC:
            begin
                state_next = sca_pkg::S_C_MUL;
            end
            sca_pkg::S_C_MUL:
            begin
                state_next = sca_pkg::S_C_ACC;
            end
            sca_pkg::S_C_ACC:
            begin
                if (comp_reg == 2'd2)
                begin
                    state_next = sca_pkg::S_SPRING_DONE;
                end
                else
                begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = sca_pkg::S_U_MUL;
                end
            end
            sca_pkg::S_SPRING_DONE:
            begin
                if (pair_reg == sca_pkg::PAIR_OLDER && stat.mid_on)
                begin
                    pair_next  = sca_pkg::PAIR_NEXT;
                    state_next = sca_pkg::S_DIFF;
                end
                else
                begin
                    comp_next  = '0;
                    state_next = sca_pkg::S_SC_HI;
                end
            end
            sca_pkg::S_SC_HI:
            begin
                state_next = sca_pkg::S_SC_LO;
            end
            sca_pkg::S_SC_LO:
            begin
                state_next = sca_pkg::S_SC_FIN;
            end
            sca_pkg::S_SC_FIN:
            begin
                if (comp_reg == 2'd2)
                begin
                    state_next = sca_pkg::S_EMIT;
                end
                else
                begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = sca_pkg::S_SC_HI;
                end
            end
            sca_pkg::S_EMIT:
            begin
                if (!stat.out_busy)
                begin
                    if (phase_reg == sca_pkg::PH_MID && stat.last)
                    begin
                        phase_next = sca_pkg::PH_LAST;
                        state_next = sca_pkg::S_CLEAR2;
                    end
                    else if (phase_reg == sca_pkg::PH_MID)
                    begin
                        state_next = sca_pkg::S_SHIFT;
                    end
                    else
                    begin
                        state_next = sca_pkg::S_IDLE;
                    end
                end
            end
            sca_pkg::S_CLEAR2:
            begin
                if (stat.mid_on)
                begin
                    pair_next  = sca_pkg::PAIR_BACK;
                    state_next = sca_pkg::S_DIFF;
                end
                else
                begin
                    comp_next  = '0;
                    state_next = sca_pkg::S_SC_HI;
                end
            end
            default:
            begin
                state_next = sca_pkg::S_IDLE;
            end
        endcase
    end

    // Command outputs.
    always_comb
    begin
        cmd.op       = sca_pkg::OP_NONE;
        cmd.comp     = comp_reg;
        cmd.pair     = pair_reg;
        cmd.mass_new = (phase_reg != sca_pkg::PH_MID);
        cmd.end_mark = (phase_reg != sca_pkg::PH_MID);
        cmd.take     = 1'b0;
        case (state_reg)
            sca_pkg::S_IDLE:        cmd.take = 1'b1;
            sca_pkg::S_DECIDE:      cmd.op = sca_pkg::OP_CLEAR_F;
            sca_pkg::S_SHIFT:       cmd.op = sca_pkg::OP_SHIFT;
            sca_pkg::S_DIFF:        cmd.op = sca_pkg::OP_DIFF;
            sca_pkg::S_SQ_MUL:      cmd.op = sca_pkg::OP_SQ_MUL;
            sca_pkg::S_SQ_ACC:      cmd.op = sca_pkg::OP_SQ_ACC;
            sca_pkg::S_ZCHK:        cmd.op = sca_pkg::OP_SQRT_INIT;
            sca_pkg::S_FLAG:        cmd.op = sca_pkg::OP_SET_FLAG;
            sca_pkg::S_SQRT:        cmd.op = sca_pkg::OP_SQRT_STEP;
            sca_pkg::S_U_MUL:       cmd.op = sca_pkg::OP_U_MUL;
            sca_pkg::S_DIV_INIT:    cmd.op = sca_pkg::OP_DIV_INIT;
            sca_pkg::S_DIV:         cmd.op = sca_pkg::OP_DIV_STEP;
            sca_pkg::S_EMAG:        cmd.op = sca_pkg::OP_EMAG;
            sca_pkg::S_K_MUL:       cmd.op = sca_pkg::OP_K_MUL;
            sca_pkg::S_K_ACC:       cmd.op = sca_pkg::OP_K_ACC;
            sca_pkg::S_C_MUL:       cmd.op = sca_pkg::OP_C_MUL;
            sca_pkg::S_C_ACC:       cmd.op = sca_pkg::OP_C_ACC;
            sca_pkg::S_SC_HI:       cmd.op = sca_pkg::OP_SC_HI;
            sca_pkg::S_SC_LO:       cmd.op = sca_pkg::OP_SC_LO;
            sca_pkg::S_SC_FIN:      cmd.op = sca_pkg::OP_SC_FIN;
            sca_pkg::S_CLEAR2:      cmd.op = sca_pkg::OP_CLEAR_F;
            sca_pkg::S_EMIT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.op = sca_pkg::OP_EMIT;
                end
            end
            default:                cmd.op = sca_pkg::OP_NONE;
        endcase
    end

endmodule

[sv/sca_dp.sv]
// ============================================================================
// sca_dp
// Datapath: particle window, shared multiplier, bit-serial square root and
// divider, force accumulators, mass scaling and the output register.
// ============================================================================
module sca_dp (
    input  logic                clk,
    input  logic                rst_n,
    sca_particle_if.sink        particle,
    sca_accel_if.source         accel,
    input  sca_pkg::sca_cmd_t   cmd,
    output sca_pkg::sca_stat_t  stat
);

    // Particle window.
    logic signed [sca_pkg::POS_W-1:0]  new_pos_reg [3];
    logic signed [sca_pkg::POS_W-1:0]  new_vel_reg [3];
    logic [sca_pkg::MASS_W-1:0]        new_mass_reg;
    logic [sca_pkg::SPR_W-1:0]         new_len_reg, new_stiff_reg, new_damp_reg;
    logic                              new_on_reg, new_last_reg;
    logic signed [sca_pkg::POS_W-1:0]  mid_pos_reg [3];
    logic signed [sca_pkg::POS_W-1:0]  mid_vel_reg [3];
    logic [sca_pkg::MASS_W-1:0]        mid_mass_reg;
    logic [sca_pkg::SPR_W-1:0]         mid_len_reg, mid_stiff_reg, mid_damp_reg;
    logic                              mid_on_reg;
    logic signed [sca_pkg::POS_W-1:0]  old_pos_reg [3];
    logic signed [sca_pkg::POS_W-1:0]  old_vel_reg [3];
    logic [sca_pkg::SPR_W-1:0]         old_len_reg, old_stiff_reg, old_damp_reg;
    logic                              old_on_reg;
    logic [1:0]                        fill_reg;
    logic [sca_pkg::CNT_W-1:0]         cnt_reg;

    // Working registers.
    logic [sca_pkg::DIF_W-1:0]         pmag_reg [3];
    logic [sca_pkg::DIF_W-1:0]         vmag_reg [3];
    logic                              pneg_reg [3];
    logic                              vneg_reg [3];
    logic [sca_pkg::SUM_W-1:0]         sum_reg;
    logic [sca_pkg::PROD_W-1:0]        prod_reg;
    logic [sca_pkg::SUM_W-1:0]         rad_reg;
    logic [sca_pkg::SREM_W-1:0]        srem_reg;
    logic [sca_pkg::ROOT_W-1:0]        root_reg;
    logic [sca_pkg::DREM_W-1:0]        drem_reg;
    logic [sca_pkg::QUO_W-1:0]         q_reg;
    logic [sca_pkg::DIF_W-1:0]         emag_reg;
    logic                              eneg_reg;
    logic signed [sca_pkg::FRC_W-1:0]  frc_reg [3];
    logic                              flag_reg;
    logic [sca_pkg::RACC_W-1:0]        racc_reg;
    logic [sca_pkg::POS_W-1:0]         acc_reg [3];
    logic                              out_valid_reg;
    sca_pkg::sca_out_t                 out_data_reg;

    // Combinational signals.
    logic                              accept;
    logic signed [sca_pkg::POS_W-1:0]  s_pos [3];
    logic signed [sca_pkg::POS_W-1:0]  s_vel [3];
    logic signed [sca_pkg::POS_W-1:0]  n_pos [3];
    logic signed [sca_pkg::POS_W-1:0]  n_vel [3];
    logic [sca_pkg::SPR_W-1:0]         spr_len, spr_stiff, spr_damp;
    logic signed [sca_pkg::DIF_W-1:0]  dpos [3];
    logic signed [sca_pkg::DIF_W-1:0]  dvel [3];
    logic [sca_pkg::MASS_W-1:0]        mass;
    logic signed [sca_pkg::FRC_W-1:0]  fsel;
    logic                              fneg;
    logic [sca_pkg::FRC_W-1:0]         fmag;
    logic [sca_pkg::DIF_W-1:0]         mul_a, mul_b;
    logic [sca_pkg::PROD_W-1:0]        mul_full;
    logic [sca_pkg::SREM_W-1:0]        srem_sh, s_trial;
    logic [sca_pkg::DREM_W:0]          d_trial, d_div, d_diff;
    logic [sca_pkg::DIF_W-1:0]         umag;
    logic signed [sca_pkg::FRC_W-1:0]  k_term, c_term;
    logic [sca_pkg::RACC_W-1:0]        r_sum;
    logic [sca_pkg::POS_W-1:0]         r_sat;

    assign accept         = particle.valid && cmd.take;
    assign particle.ready = cmd.take;

    // Subject and neighbour of the spring being worked on.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            case (cmd.pair)
                sca_pkg::PAIR_OLDER:
                begin
                    s_pos[i] = mid_pos_reg[i];
                    s_vel[i] = mid_vel_reg[i];
                    n_pos[i] = old_pos_reg[i];
                    n_vel[i] = old_vel_reg[i];
                end
                sca_pkg::PAIR_NEXT:
                begin
                    s_pos[i] = mid_pos_reg[i];
                    s_vel[i] = mid_vel_reg[i];
                    n_pos[i] = new_pos_reg[i];
                    n_vel[i] = new_vel_reg[i];
                end
                default:
                begin
                    s_pos[i] = new_pos_reg[i];
                    s_vel[i] = new_vel_reg[i];
                    n_pos[i] = mid_pos_reg[i];
                    n_vel[i] = mid_vel_reg[i];
                end
            endcase
            dpos[i] = sca_pkg::DIF_W'(n_pos[i]) - sca_pkg::DIF_W'(s_pos[i]);
            dvel[i] = sca_pkg::DIF_W'(n_vel[i]) - sca_pkg::DIF_W'(s_vel[i]);
        end
    end

    // Spring constants follow the older spring only for the older pair.
    always_comb
    begin
        if (cmd.pair == sca_pkg::PAIR_OLDER)
        begin
            spr_len   = old_len_reg;
            spr_stiff = old_stiff_reg;
            spr_damp  = old_damp_reg;
        end
        else
        begin
            spr_len   = mid_len_reg;
            spr_stiff = mid_stiff_reg;
            spr_damp  = mid_damp_reg;
        end
    end

    // Force magnitude and the mass it is scaled by.
    assign mass = cmd.mass_new ? new_mass_reg : mid_mass_reg;
    assign fsel = frc_reg[cmd.comp];
    assign fneg = fsel[sca_pkg::FRC_W-1];
    assign fmag = fneg ? sca_pkg::FRC_W'(-fsel) : sca_pkg::FRC_W'(fsel);

    // Shared multiplier operand selection.
    always_comb
    begin
        case (cmd.op)
            sca_pkg::OP_SQ_MUL:
            begin
                mul_a = pmag_reg[cmd.comp];
                mul_b = pmag_reg[cmd.comp];
            end
            sca_pkg::OP_U_MUL:
            begin
                mul_a = pmag_reg[cmd.comp];
                mul_b = sca_pkg::DIF_W'(spr_len);
            end
            sca_pkg::OP_K_MUL:
            begin
                mul_a = emag_reg;
                mul_b = sca_pkg::DIF_W'(spr_stiff);
            end
            sca_pkg::OP_C_MUL:
            begin
                mul_a = vmag_reg[cmd.comp];
                mul_b = sca_pkg::DIF_W'(spr_damp);
            end
            sca_pkg::OP_SC_HI:
            begin
                mul_a = sca_pkg::DIF_W'(fmag[sca_pkg::FRC_W-1:25]);
                mul_b = sca_pkg::DIF_W'(mass);
            end
            sca_pkg::OP_SC_LO:
            begin
                mul_a = sca_pkg::DIF_W'(fmag[24:0]);
                mul_b = sca_pkg::DIF_W'(mass);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_full = mul_a * mul_b;

    // One step of the square root and of the divider.
    assign srem_sh = {srem_reg[sca_pkg::SREM_W-3:0], rad_reg[sca_pkg::SUM_W-1 -: 2]};
    assign s_trial = {1'b0, root_reg, 2'b01};
    assign d_trial = {drem_reg, q_reg[sca_pkg::QUO_W-1]};
    assign d_div   = {1'b0, root_reg};
    assign d_diff  = d_trial - d_div;
    assign umag    = {1'b0, q_reg};

    // Truncated force terms.
    assign k_term = sca_pkg::FRC_W'(prod_reg[63:16]);
    assign c_term = sca_pkg::FRC_W'(prod_reg[63:16]);

    // Scaled acceleration with saturation.
    assign r_sum = racc_reg + sca_pkg::RACC_W'(prod_reg[48:16]);
    always_comb
    begin
        if (fneg)
        begin
            if (r_sum >= sca_pkg::RACC_W'(64'h8000_0000))
            begin
                r_sat = 32'h8000_0000;
            end
            else
            begin
                r_sat = sca_pkg::POS_W'(sca_pkg::RACC_W'(0) - r_sum);
            end
        end
        else if (r_sum > sca_pkg::RACC_W'(64'h7FFF_FFFF))
        begin
            r_sat = 32'h7FFF_FFFF;
        end
        else
        begin
            r_sat = r_sum[sca_pkg::POS_W-1:0];
        end
    end

    // Control state: window fill, particle counter, output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.op == sca_pkg::OP_EMIT)
            begin
                out_valid_reg <= 1'b1;
                if (cmd.end_mark)
                begin
                    fill_reg <= '0;
                    cnt_reg  <= '0;
                end
                else if (cnt_reg == sca_pkg::CNT_W'(sca_pkg::MAX_PARTICLES - 1))
                begin
                    cnt_reg <= '0;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            else if (accel.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.op == sca_pkg::OP_SHIFT)
            begin
                fill_reg <= (fill_reg == 2'd0) ? 2'd1 : 2'd2;
            end
        end
    end

    // Incoming particle latch and window shift.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            new_pos_reg[0] <= particle.data.pos_x;
            new_pos_reg[1] <= particle.data.pos_y;
            new_pos_reg[2] <= particle.data.pos_z;
            new_vel_reg[0] <= particle.data.vel_x;
            new_vel_reg[1] <= particle.data.vel_y;
            new_vel_reg[2] <= particle.data.vel_z;
            new_mass_reg   <= particle.data.inv_mass;
            new_len_reg    <= particle.data.spring_rest_length;
            new_stiff_reg  <= particle.data.spring_stiffness;
            new_damp_reg   <= particle.data.spring_damping;
            new_on_reg     <= particle.data.spring_active;
            new_last_reg   <= particle.data.last_particle;
        end
        if (cmd.op == sca_pkg::OP_SHIFT)
        begin
            old_pos_reg   <= mid_pos_reg;
            old_vel_reg   <= mid_vel_reg;
            old_len_reg   <= mid_len_reg;
            old_stiff_reg <= mid_stiff_reg;
            old_damp_reg  <= mid_damp_reg;
            old_on_reg    <= mid_on_reg;
            mid_pos_reg   <= new_pos_reg;
            mid_vel_reg   <= new_vel_reg;
            mid_mass_reg  <= new_mass_reg;
            mid_len_reg   <= new_len_reg;
            mid_stiff_reg <= new_stiff_reg;
            mid_damp_reg  <= new_damp_reg;
            mid_on_reg    <= new_on_reg;
        end
    end

    // Arithmetic working registers.
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            sca_pkg::OP_CLEAR_F:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    frc_reg[i] <= '0;
                end
                flag_reg <= 1'b0;
            end
            sca_pkg::OP_DIFF:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    pneg_reg[i] <= dpos[i][sca_pkg::DIF_W-1];
                    vneg_reg[i] <= dvel[i][sca_pkg::DIF_W-1];
                    pmag_reg[i] <= dpos[i][sca_pkg::DIF_W-1] ?
                                   sca_pkg::DIF_W'(-dpos[i]) : sca_pkg::DIF_W'(dpos[i]);
                    vmag_reg[i] <= dvel[i][sca_pkg::DIF_W-1] ?
                                   sca_pkg::DIF_W'(-dvel[i]) : sca_pkg::DIF_W'(dvel[i]);
                end
                sum_reg <= '0;
            end
            sca_pkg::OP_SQ_MUL, sca_pkg::OP_U_MUL, sca_pkg::OP_K_MUL,
            sca_pkg::OP_C_MUL, sca_pkg::OP_SC_HI:
            begin
                prod_reg <= mul_full;
            end
            sca_pkg::OP_SQ_ACC:
            begin
                sum_reg <= sum_reg + prod_reg;
            end
            sca_pkg::OP_SET_FLAG:
            begin
                flag_reg <= 1'b1;
            end
            sca_pkg::OP_SQRT_INIT:
            begin
                rad_reg  <= sum_reg;
                srem_reg <= '0;
                root_reg <= '0;
            end
            sca_pkg::OP_SQRT_STEP:
            begin
                rad_reg <= {rad_reg[sca_pkg::SUM_W-3:0], 2'b00};
                if (srem_sh >= s_trial)
                begin
                    srem_reg <= srem_sh - s_trial;
                    root_reg <= {root_reg[sca_pkg::ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    srem_reg <= srem_sh;
                    root_reg <= {root_reg[sca_pkg::ROOT_W-2:0], 1'b0};
                end
            end
            sca_pkg::OP_DIV_INIT:
            begin
                drem_reg <= sca_pkg::DREM_W'(prod_reg[63:32]);
                q_reg    <= prod_reg[31:0];
            end
            sca_pkg::OP_DIV_STEP:
            begin
                if (d_trial >= d_div)
                begin
                    drem_reg <= d_diff[sca_pkg::DREM_W-1:0];
                    q_reg    <= {q_reg[sca_pkg::QUO_W-2:0], 1'b1};
                end
                else
                begin
                    drem_reg <= d_trial[sca_pkg::DREM_W-1:0];
                    q_reg    <= {q_reg[sca_pkg::QUO_W-2:0], 1'b0};
                end
            end
            sca_pkg::OP_EMAG:
            begin
                if (pmag_reg[cmd.comp] >= umag)
                begin
                    emag_reg <= pmag_reg[cmd.comp] - umag;
                    eneg_reg <= pneg_reg[cmd.comp];
                end
                else
                begin
                    emag_reg <= umag - pmag_reg[cmd.comp];
                    eneg_reg <= !pneg_reg[cmd.comp];
                end
            end
            sca_pkg::OP_K_ACC:
            begin
                frc_reg[cmd.comp] <= eneg_reg ? frc_reg[cmd.comp] - k_term
                                              : frc_reg[cmd.comp] + k_term;
            end
            sca_pkg::OP_C_ACC:
            begin
                frc_reg[cmd.comp] <= vneg_reg[cmd.comp] ? frc_reg[cmd.comp] - c_term
                                                        : frc_reg[cmd.comp] + c_term;
            end
            sca_pkg::OP_SC_LO:
            begin
                racc_reg <= sca_pkg::RACC_W'(prod_reg[49:0]) << 9;
                prod_reg <= mul_full;
            end
            sca_pkg::OP_SC_FIN:
            begin
                acc_reg[cmd.comp] <= r_sat;
            end
            sca_pkg::OP_EMIT:
            begin
                out_data_reg.accel_x          <= acc_reg[0];
                out_data_reg.accel_y          <= acc_reg[1];
                out_data_reg.accel_z          <= acc_reg[2];
                out_data_reg.particle_index   <= sca_pkg::IDX_W'(cnt_reg);
                out_data_reg.zero_length_flag <= flag_reg;
                out_data_reg.end_of_chain     <= cmd.end_mark;
            end
            default:
            begin
            end
        endcase
    end

    // Status to the controller and the result channel.
    assign stat.in_valid = particle.valid;
    assign stat.fill     = fill_reg;
    assign stat.last     = new_last_reg;
    assign stat.mid_on   = mid_on_reg;
    assign stat.older_on = old_on_reg;
    assign stat.sum_zero = (sum_reg == '0);
    assign stat.out_busy = out_valid_reg;

    assign accel.valid = out_valid_reg;
    assign accel.data  = out_data_reg;

    // A new result is only loaded into an empty output register.
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == sca_pkg::OP_EMIT |-> !out_valid_reg)
        else $error("result loaded over a pending result");

    // The window never holds more than two stored particles.
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg != 2'd3)
        else $error("window fill out of range");

    // A division only starts on a nonzero distance.
    a_root_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == sca_pkg::OP_DIV_INIT |-> root_reg != '0)
        else $error("division by zero distance");

    // The scaled rest length never exceeds 31 bits.
    a_quot_fits: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == sca_pkg::OP_EMAG |-> !q_reg[sca_pkg::QUO_W-1])
        else $error("rest length quotient overflow");

endmodule

[sv/spring_chain_acceleration.sv]
// ============================================================================
// spring_chain_acceleration
// Acceleration of each particle of a mass-spring-damper chain from the
// damped spring forces of its neighbours, scaled by its inverse mass.
//
//   Channel   Role   Handshake     Moves
//   particle  sink   valid/ready   one particle request with its spring
//   accel     source valid/ready   one acceleration result (0 to 2 per request)
//
// A request is taken only while the sequencer is idle. Each active spring
// passes through one difference step, the squares of the three axes, a zero
// check, 33 root steps, then per axis a 32-step divide and the multiply,
// compare and accumulate steps, and one closing step; each result then goes
// through mass scaling, all on one shared multiplier, root and divide unit.
// Reset empties the window and clears the counter. The output register holds
// a result until taken and the next request is accepted meanwhile; a second
// result waits for it.
// ============================================================================
module spring_chain_acceleration (
    input  logic           clk,
    input  logic           rst_n,
    sca_particle_if.sink   particle,
    sca_accel_if.source    accel
);

    sca_pkg::sca_cmd_t  cmd;
    sca_pkg::sca_stat_t stat;

    // Sequencer.
    sca_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    // Arithmetic and window storage.
    sca_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .particle (particle),
        .accel    (accel),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

[tb/tb_spring_chain_acceleration.sv]
// ============================================================================
// tb_spring_chain_acceleration
// Self-checking bench for the spring chain acceleration block. A directed
// table of chains runs first, then random chains. Each request is applied to
// a behavioral force model and the predicted accelerations are queued. Every
// result taken from the block is compared field by field against that queue.
// ============================================================================
module tb_spring_chain_acceleration;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint CYCLE_LIMIT = 4000000;

    logic clk;
    logic rst_n;

    sca_particle_if particle ();
    sca_accel_if    accel ();

    spring_chain_acceleration dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .particle (particle.sink),
        .accel    (accel.source)
    );

    // Chain window held by the force model.
    logic signed [63:0] old_p [3];
    logic signed [63:0] old_v [3];
    logic [30:0]        old_len, old_k, old_c;
    logic               old_on;
    logic signed [63:0] mid_p [3];
    logic signed [63:0] mid_v [3];
    logic [23:0]        mid_m;
    logic [30:0]        mid_len, mid_k, mid_c;
    logic               mid_on;
    int                 fill;
    int                 pcount;

    sca_pkg::sca_out_t accel_queue [$];

    int  errors;
    int  requests_sent;
    int  results_seen;
    int  flags_seen;
    int  ends_seen;
    int  sat_seen;
    bit  long_stall;
    bit  stall_issued;
    longint cycles;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Cycle counter and timeout.
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("timeout: %0d results still expected", accel_queue.size());
                $display("** spring_chain_acceleration: FAILED **");
                $finish;
            end
        end
    end

    // Integer square root, floor, of a 128-bit sum.
    function automatic logic [63:0] floor_root(logic [127:0] s);
        logic [63:0]  r;
        logic [63:0]  c;
        logic [127:0] sq;
        r = 0;
        for (int b = 33; b >= 0; b--)
        begin
            c  = r | (64'd1 << b);
            sq = c * c;
            if (sq <= s)
                r = c;
        end
        return r;
    endfunction

    // Adds the damped force of neighbour n on particle s into f.
    // Returns 1 when the two particles coincide.
    function automatic bit add_spring(input logic signed [63:0] sp [3],
                                      input logic signed [63:0] sv [3],
                                      input logic signed [63:0] np [3],
                                      input logic signed [63:0] nv [3],
                                      input logic [30:0] len, input logic [30:0] k,
                                      input logic [30:0] c,
                                      inout logic signed [63:0] f [3]);
        logic signed [63:0] dp [3];
        logic signed [63:0] dv [3];
        logic [63:0]  mag [3];
        logic [63:0]  vm, umag, emag, d, t;
        logic [127:0] sum;
        bit eneg;
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            dp[i]  = np[i] - sp[i];
            dv[i]  = nv[i] - sv[i];
            mag[i] = dp[i] < 0 ? -dp[i] : dp[i];
            sum   += 128'(mag[i]) * 128'(mag[i]);
        end
        if (sum == 0)
            return 1'b1;
        d = floor_root(sum);
        for (int i = 0; i < 3; i++)
        begin
            umag = (64'(len) * mag[i]) / d;
            if (mag[i] >= umag)
            begin
                emag = mag[i] - umag;
                eneg = dp[i] < 0;
            end
            else
            begin
                emag = umag - mag[i];
                eneg = !(dp[i] < 0);
            end
            t = (emag * 64'(k)) >> 16;
            f[i] += eneg ? -$signed(t) : $signed(t);
            vm = dv[i] < 0 ? -dv[i] : dv[i];
            t = (vm * 64'(c)) >> 16;
            f[i] += dv[i] < 0 ? -$signed(t) : $signed(t);
        end
        return 1'b0;
    endfunction

    // Force times inverse mass, truncated on the magnitude and saturated.
    function automatic logic [31:0] scale_force(logic signed [63:0] force_in, logic [23:0] m);
        logic [63:0] mag;
        logic [63:0] r;
        mag = force_in < 0 ? -force_in : force_in;
        r = (((mag >> 25) * 64'(m)) << 9) + (((mag & 64'h1FF_FFFF) * 64'(m)) >> 16);
        if (force_in < 0)
            return r >= 64'h8000_0000 ? 32'h8000_0000 : 32'(-r);
        return r > 64'h7FFF_FFFF ? 32'h7FFF_FFFF : r[31:0];
    endfunction

    function automatic sca_pkg::sca_out_t make_accel(logic signed [63:0] f [3],
                                                     logic [23:0] m,
                                                     int idx, bit flag, bit eoc);
        sca_pkg::sca_out_t o;
        o.accel_x          = scale_force(f[0], m);
        o.accel_y          = scale_force(f[1], m);
        o.accel_z          = scale_force(f[2], m);
        o.particle_index   = idx[sca_pkg::IDX_W-1:0];
        o.zero_length_flag = flag;
        o.end_of_chain     = eoc;
        return o;
    endfunction

    // Force model: advances the window by one request, queues its results.
    task automatic predict_chain(sca_pkg::sca_in_t r);
        logic signed [63:0] p [3];
        logic signed [63:0] v [3];
        logic signed [63:0] f [3];
        logic signed [63:0] g [3];
        bit flag;
        bit gflag;
        p = '{64'(r.pos_x), 64'(r.pos_y), 64'(r.pos_z)};
        v = '{64'(r.vel_x), 64'(r.vel_y), 64'(r.vel_z)};
        f = '{0, 0, 0};
        g = '{0, 0, 0};
        flag = 0;
        gflag = 0;
        if (fill == 0)
        begin
            if (r.last_particle)
            begin
                accel_queue.push_back(make_accel(f, r.inv_mass, pcount, 0, 1));
                pcount = 0;
                return;
            end
            mid_p = p; mid_v = v; mid_m = r.inv_mass;
            mid_len = r.spring_rest_length; mid_k = r.spring_stiffness;
            mid_c = r.spring_damping; mid_on = r.spring_active;
            fill = 1;
            return;
        end
        if (fill == 2 && old_on)
            flag |= add_spring(mid_p, mid_v, old_p, old_v, old_len, old_k, old_c, f);
        if (mid_on)
            flag |= add_spring(mid_p, mid_v, p, v, mid_len, mid_k, mid_c, f);
        accel_queue.push_back(make_accel(f, mid_m, pcount, flag, 0));
        pcount = (pcount + 1) % sca_pkg::MAX_PARTICLES;
        if (r.last_particle)
        begin
            if (mid_on)
                gflag = add_spring(p, v, mid_p, mid_v, mid_len, mid_k, mid_c, g);
            accel_queue.push_back(make_accel(g, r.inv_mass, pcount, gflag, 1));
            fill = 0;
            pcount = 0;
            return;
        end
        old_p = mid_p; old_v = mid_v; old_len = mid_len; old_k = mid_k;
        old_c = mid_c; old_on = mid_on;
        mid_p = p; mid_v = v; mid_m = r.inv_mass;
        mid_len = r.spring_rest_length; mid_k = r.spring_stiffness;
        mid_c = r.spring_damping; mid_on = r.spring_active;
        fill = 2;
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch on %s at result %0d: got %0h, expected %0h",
                 what, results_seen, got, want);
        errors++;
    endtask

    // Receiver: random stall pattern plus one long hold-off.
    int stall_left;
    initial
    begin
        accel.ready = 1'b0;
        stall_left  = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_stall)
            begin
                accel.ready = 1'b0;
                stall_left  = 3000;
                long_stall  = 0;
            end
            else if (stall_left > 0)
            begin
                accel.ready = 1'b0;
                stall_left--;
            end
            else if (cycles % 4096 < 1500)
                accel.ready = 1'b1;
            else
                accel.ready = ($urandom_range(0, 3) != 0);
        end
    end

    // Result checker.
    sca_pkg::sca_out_t want;
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && accel.valid && accel.ready)
            begin
                if (accel_queue.size() == 0)
                begin
                    report_mismatch("unexpected result", 1, 0);
                end
                else
                begin
                    want = accel_queue.pop_front();
                    if (accel.data.accel_x !== want.accel_x)
                        report_mismatch("accel_x", accel.data.accel_x, want.accel_x);
                    if (accel.data.accel_y !== want.accel_y)
                        report_mismatch("accel_y", accel.data.accel_y, want.accel_y);
                    if (accel.data.accel_z !== want.accel_z)
                        report_mismatch("accel_z", accel.data.accel_z, want.accel_z);
                    if (accel.data.particle_index !== want.particle_index)
                        report_mismatch("particle_index", accel.data.particle_index,
                                        want.particle_index);
                    if (accel.data.zero_length_flag !== want.zero_length_flag)
                        report_mismatch("zero_length_flag", accel.data.zero_length_flag,
                                        want.zero_length_flag);
                    if (accel.data.end_of_chain !== want.end_of_chain)
                        report_mismatch("end_of_chain", accel.data.end_of_chain,
                                        want.end_of_chain);
                    if (want.zero_length_flag)
                        flags_seen++;
                    if (want.end_of_chain)
                        ends_seen++;
                    if (want.accel_x == 32'h7FFF_FFFF || want.accel_x == 32'h8000_0000)
                        sat_seen++;
                end
                results_seen++;
            end
        end
    end

    // Sends one request, holding it until accepted.
    task automatic send_particle(sca_pkg::sca_in_t r);
        particle.data  <= r;
        particle.valid <= 1'b1;
        do
            @(posedge clk);
        while (!particle.ready);
        predict_chain(r);
        requests_sent++;
        @(negedge clk);
    endtask

    task automatic drop_valid();
        particle.valid <= 1'b0;
    endtask

    // Random coordinate: mostly small, sometimes full range.
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0:       return $urandom();
            1:       return {$urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000};
            default: return 32'($signed($urandom_range(0, 20'hFFFFF)) - 32'sh80000);
        endcase
    endfunction

    function automatic sca_pkg::sca_in_t rand_particle(bit last);
        sca_pkg::sca_in_t r;
        r.pos_x = rand_coord();
        r.pos_y = rand_coord();
        r.pos_z = rand_coord();
        r.vel_x = rand_coord();
        r.vel_y = rand_coord();
        r.vel_z = rand_coord();
        r.inv_mass = ($urandom_range(0, 5) == 0) ? 24'($urandom())
                                                  : 24'($urandom_range(0, 24'h3FFFF));
        r.spring_rest_length = ($urandom_range(0, 5) == 0) ? 31'($urandom())
                                                            : 31'($urandom_range(0, 24'h3FFFFF));
        r.spring_stiffness = ($urandom_range(0, 5) == 0) ? 31'($urandom())
                                                          : 31'($urandom_range(0, 24'h3FFFF));
        r.spring_damping = ($urandom_range(0, 5) == 0) ? 31'($urandom())
                                                        : 31'($urandom_range(0, 24'h3FFFF));
        r.spring_active = ($urandom_range(0, 7) != 0);
        r.last_particle = last;
        return r;
    endfunction

    // Directed table: a few short chains touching the corners.
    sca_pkg::sca_in_t directed [20];
    sca_pkg::sca_out_t dir_result;

    task automatic build_table();
        sca_pkg::sca_in_t z;
        z = '0;
        // Single-particle chain.
        directed[0] = z;
        directed[0].inv_mass = 24'hFFFFFF;
        directed[0].last_particle = 1;
        // Two coincident particles with an active spring.
        directed[1] = z; directed[1].spring_active = 1; directed[1].inv_mass = 24'h010000;
        directed[2] = z; directed[2].last_particle = 1; directed[2].inv_mass = 24'h010000;
        // Extreme opposite corners, stiff spring, full inverse mass.
        directed[3] = z;
        directed[3].pos_x = 32'h8000_0000; directed[3].pos_y = 32'h8000_0000;
        directed[3].pos_z = 32'h8000_0000; directed[3].vel_x = 32'h7FFF_FFFF;
        directed[3].inv_mass = 24'hFFFFFF; directed[3].spring_active = 1;
        directed[3].spring_stiffness = 31'h7FFF_FFFF; directed[3].spring_damping = 31'h7FFF_FFFF;
        directed[4] = z;
        directed[4].pos_x = 32'h7FFF_FFFF; directed[4].pos_y = 32'h7FFF_FFFF;
        directed[4].pos_z = 32'h7FFF_FFFF; directed[4].vel_x = 32'h8000_0000;
        directed[4].vel_y = 32'hFFFF_FFFF; directed[4].vel_z = 32'h8000_0000;
        directed[4].inv_mass = 24'hFFFFFF; directed[4].spring_active = 1;
        directed[4].spring_rest_length = 31'h7FFF_FFFF;
        directed[4].spring_stiffness = 31'h7FFF_FFFF; directed[4].spring_damping = 31'h7FFF_FFFF;
        // Long rest length, inactive spring, then final particle whose spring is ignored.
        directed[5] = z; directed[5].pos_y = 32'h0001_0000; directed[5].inv_mass = 24'h008000;
        directed[5].spring_rest_length = 31'h7FFF_FFFF; directed[5].spring_stiffness = 31'h10000;
        directed[5].spring_active = 1;
        directed[6] = z; directed[6].pos_z = 32'h0003_0000; directed[6].inv_mass = 24'h020000;
        directed[6].spring_active = 0;
        directed[7] = z; directed[7].pos_x = 32'h0005_0000; directed[7].last_particle = 1;
        directed[7].spring_active = 1; directed[7].spring_stiffness = 31'h7FFF_FFFF;
        directed[7].spring_damping = 31'h7FFF_FFFF; directed[7].inv_mass = 24'h010000;
        for (int i = 8; i < 20; i++)
            directed[i] = rand_particle(i == 13 || i == 19);
    endtask

    // Stimulus.
    int burst;
    int chain_len;
    initial
    begin
        errors = 0; requests_sent = 0; results_seen = 0;
        flags_seen = 0; ends_seen = 0; sat_seen = 0;
        long_stall = 0; stall_issued = 0;
        fill = 0; pcount = 0;
        old_p = '{0, 0, 0}; old_v = '{0, 0, 0}; mid_p = '{0, 0, 0}; mid_v = '{0, 0, 0};
        old_len = 0; old_k = 0; old_c = 0; old_on = 0;
        mid_m = 0; mid_len = 0; mid_k = 0; mid_c = 0; mid_on = 0;
        particle.valid = 1'b0;
        particle.data  = '0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        build_table();

        // Directed part; the first row's result is known outright.
        for (int i = 0; i < 20; i++)
        begin
            send_particle(directed[i]);
            if (i == 0)
            begin
                dir_result = '0;
                dir_result.end_of_chain = 1;
                if (accel_queue[0] !== dir_result)
                begin
                    $display("single-particle prediction off");
                    errors++;
                end
            end
        end
        drop_valid();

        // Wait for every result before the random part.
        while (accel_queue.size() != 0)
            @(negedge clk);

        // Random chains with bursts, gaps and one long receiver hold-off.
        burst = 0;
        while (requests_sent < 930)
        begin
            if ($urandom_range(0, 9) == 0)
                chain_len = 1;
            else if ($urandom_range(0, 49) == 0)
                chain_len = $urandom_range(20, 60);
            else
                chain_len = $urandom_range(2, 8);
            if (requests_sent >= 400 && !stall_issued)
            begin
                long_stall   = 1;
                stall_issued = 1;
            end
            for (int j = 0; j < chain_len; j++)
            begin
                if (burst == 0)
                begin
                    drop_valid();
                    repeat ($urandom_range(0, 40)) @(negedge clk);
                    burst = $urandom_range(1, 12);
                end
                send_particle(rand_particle(j == chain_len - 1));
                burst--;
            end
        end
        drop_valid();

        while (accel_queue.size() != 0)
            @(negedge clk);
        repeat (800) @(negedge clk);

        $display("%0d requests, %0d results, %0d chains ended, %0d zero-distance flags,",
                 requests_sent, results_seen, ends_seen, flags_seen);
        $display("%0d saturated x results, %0d mismatches", sat_seen, errors);
        if (errors == 0 && accel_queue.size() == 0)
            $display("** spring_chain_acceleration: PASSED **");
        else
            $display("** spring_chain_acceleration: FAILED **");
        $finish;
    end
endmodule

[spring_chain_acceleration.f]
sv/sca_pkg.sv
sv/sca_if.sv
sv/sca_ctrl.sv
sv/sca_dp.sv
sv/spring_chain_acceleration.sv
tb/tb_spring_chain_acceleration.sv
